[src/cubic_bezier_evaluator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Bezier evaluator
// Shared forms for same-cycle and next-cycle implications on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EVALUATOR_TOP_ASSERT_SVH
`define CUBIC_BEZIER_EVALUATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BEZ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BEZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bez_pkg.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator package
// Default widths and the register index codes of the configuration port.
// ----------------------------------------------------------------------------
package bez_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_LEAD_X,
    REG_LEAD_Y,
    REG_TRAIL_X,
    REG_TRAIL_Y,
    REG_END_X,
    REG_END_Y
  } cfg_reg_t;

endpackage

[src/bez_lerp_cell.sv]
// ----------------------------------------------------------------------------
// Exact interpolation cell
// Computes y = a*(2^F - t) + b*t = a*2^F + (b - a)*t without rounding, in
// three register stages: difference, split partial products, final sum.
// ----------------------------------------------------------------------------
module bez_lerp_cell #(
  parameter int IW = 32,
  parameter int F  = 16
) (
  input  logic                    clk,
  input  logic [2:0]              stage_en,
  input  logic signed [IW-1:0]    a,
  input  logic signed [IW-1:0]    b,
  input  logic [F:0]              t,
  output logic signed [IW+F-1:0]  y
);

  localparam int DW   = IW + 1;
  localparam int LO_W = DW / 2;
  localparam int HI_W = DW - LO_W;
  localparam int TW   = F + 1;
  localparam int OW   = IW + F;
  localparam int PLW  = LO_W + TW;
  localparam int PHW  = HI_W + TW + 1;

  logic [DW-1:0]          d_r;
  logic signed [IW-1:0]   a1_r;
  logic [TW-1:0]          t1_r;
  logic [PLW-1:0]         plo_r;
  logic [PLW-1:0]         plo_nxt;
  logic signed [PHW-1:0]  phi_r;
  logic signed [PHW-1:0]  phi_nxt;
  logic signed [IW-1:0]   a2_r;
  logic signed [OW-1:0]   y_r;
  logic signed [OW-1:0]   y_nxt;

  // The high half of the difference carries the sign; the low half is unsigned.
  always_comb begin
    plo_nxt = PLW'(d_r[LO_W-1:0]) * PLW'(t1_r);
    phi_nxt = PHW'($signed(d_r[DW-1:LO_W])) * PHW'($signed({1'b0, t1_r}));
    y_nxt   = (OW'(a2_r) <<< F) + OW'(plo_r) + (OW'(phi_r) <<< LO_W);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      d_r  <= {b[IW-1], b} - {a[IW-1], a};
      a1_r <= a;
      t1_r <= t;
    end
    if (stage_en[1]) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
      a2_r  <= a1_r;
    end
    if (stage_en[2]) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

[src/bez_round_sat.sv]
// ----------------------------------------------------------------------------
// Round and saturate stage
// Drops K fraction bits with round to nearest, ties up, then clamps to a
// signed OW-bit value; the result is registered.
// ----------------------------------------------------------------------------
module bez_round_sat #(
  parameter int IW = 64,
  parameter int K  = 16,
  parameter int OW = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [IW-1:0]  raw,
  output logic signed [OW-1:0]  res
);

  localparam int SW = IW + 1 - K;
  localparam logic [IW:0] HALF = (IW + 1)'(1) << (K - 1);

  logic [IW:0]          sum;
  logic [SW-1:0]        sh;
  logic [SW-OW:0]       top_bits;
  logic signed [OW-1:0] res_r;
  logic signed [OW-1:0] res_nxt;

  always_comb begin
    sum      = {raw[IW-1], raw} + HALF;
    sh       = sum[IW:K];
    top_bits = sh[SW-1:OW-1];
    if ((&top_bits) || !(|top_bits)) begin
      res_nxt = sh[OW-1:0];
    end else if (sh[SW-1]) begin
      res_nxt = {1'b1, {(OW-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(OW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[src/cubic_bezier_evaluator_top.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator, top level
// Evaluates a 2-D cubic Bezier curve and its first two derivatives at t.
// ----------------------------------------------------------------------------
// Usage: write the four control points (signed Q16.16 at the default width)
// through the cfg_ port while no item is in flight, then send curve
// parameters t in unsigned Q1.F on in_param_t; a value above 1.0 is treated
// as 1.0. Every item gives one result item with the curve point, the first
// derivative and the second derivative, each rounded to nearest (ties up)
// and saturated to a signed COORD_WIDTH-bit value. The block takes one item
// per clock cycle while the output side does not stall. The pipeline holds
// three rows of de Casteljau interpolation cells, three register stages
// each, between an input register and the rounding register. A stalled
// output lets the earlier stages keep filling, so items are still taken
// until every stage holds one.
// ----------------------------------------------------------------------------
module cubic_bezier_evaluator_top
  import bez_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [T_FRAC_BITS:0]          in_param_t,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_pos_x,
  output logic signed [COORD_WIDTH-1:0] out_pos_y,
  output logic signed [COORD_WIDTH-1:0] out_vel_x,
  output logic signed [COORD_WIDTH-1:0] out_vel_y,
  output logic signed [COORD_WIDTH-1:0] out_acc_x,
  output logic signed [COORD_WIDTH-1:0] out_acc_y
);

  `include "cubic_bezier_evaluator_top_assert.svh"

  localparam int CW   = COORD_WIDTH;
  localparam int F    = T_FRAC_BITS;
  localparam int TW   = F + 1;
  localparam int QW   = CW + F;       // first-level points, scale 2^F
  localparam int RW   = CW + 2 * F;   // second-level points, scale 2^2F
  localparam int PW   = CW + 3 * F;   // curve point, scale 2^3F
  localparam int EW   = QW + 2;       // second difference
  localparam int AW   = QW + 5;       // six times the second difference
  localparam int DVW  = RW + 1;       // first difference
  localparam int VW   = RW + 3;       // three times the first difference
  localparam int NSTG = 11;
  localparam logic [TW-1:0] T_ONE = {1'b1, {F{1'b0}}};

  // Control point registers.
  logic signed [CW-1:0] ctrl_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      ctrl_r[cfg_index] <= cfg_data;
    end
  end

  // Stage valid bits. A stage loads whenever it is empty or its successor
  // loads, so bubbles are squeezed out while the output is held.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

  // Clamped parameter travels alongside the cells that need it.
  logic [TW-1:0] t_r [7];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_r[0] <= (in_param_t > T_ONE) ? T_ONE : in_param_t;
    end
    for (int i = 1; i < 7; i++) begin
      if (en[i]) begin
        t_r[i] <= t_r[i-1];
      end
    end
  end

  logic signed [CW-1:0] pos_o [2];
  logic signed [CW-1:0] vel_o [2];
  logic signed [CW-1:0] acc_o [2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [CW-1:0]  pt [4];
    logic signed [QW-1:0]  q  [3];
    logic signed [RW-1:0]  r  [2];
    logic signed [PW-1:0]  pos_raw;
    logic signed [EW-1:0]  e4_r;
    logic signed [AW-1:0]  acc_d_r [5:9];
    logic signed [DVW-1:0] dv7_r;
    logic signed [VW-1:0]  v8_r;
    logic signed [VW-1:0]  v9_r;

    assign pt[0] = ctrl_r[REG_IDX_W'(int'(REG_START_X) + ax)];
    assign pt[1] = ctrl_r[REG_IDX_W'(int'(REG_LEAD_X) + ax)];
    assign pt[2] = ctrl_r[REG_IDX_W'(int'(REG_TRAIL_X) + ax)];
    assign pt[3] = ctrl_r[REG_IDX_W'(int'(REG_END_X) + ax)];

    // First row: three cells between neighboring control points.
    for (genvar i = 0; i < 3; i++) begin : g_row1
      bez_lerp_cell #(.IW(CW), .F(F)) u_cell (
        .clk      (clk),
        .stage_en (en[3:1]),
        .a        (pt[i]),
        .b        (pt[i+1]),
        .t        (t_r[0]),
        .y        (q[i])
      );
    end

    // Second row: two cells.
    for (genvar i = 0; i < 2; i++) begin : g_row2
      bez_lerp_cell #(.IW(QW), .F(F)) u_cell (
        .clk      (clk),
        .stage_en (en[6:4]),
        .a        (q[i]),
        .b        (q[i+1]),
        .t        (t_r[3]),
        .y        (r[i])
      );
    end

    // Last row: one cell gives the curve point.
    bez_lerp_cell #(.IW(RW), .F(F)) u_row3 (
      .clk      (clk),
      .stage_en (en[9:7]),
      .a        (r[0]),
      .b        (r[1]),
      .t        (t_r[6]),
      .y        (pos_raw)
    );

    // The second derivative is six times the second difference of the
    // first-row points; it waits in a delay line for the curve point.
    always_ff @(posedge clk) begin
      if (en[4]) begin
        e4_r <= EW'(q[0]) - (EW'(q[1]) <<< 1) + EW'(q[2]);
      end
      if (en[5]) begin
        acc_d_r[5] <= (AW'(e4_r) <<< 2) + (AW'(e4_r) <<< 1);
      end
      for (int k = 6; k <= 9; k++) begin
        if (en[k]) begin
          acc_d_r[k] <= acc_d_r[k-1];
        end
      end
    end

    // The first derivative is three times the difference of the
    // second-row points.
    always_ff @(posedge clk) begin
      if (en[7]) begin
        dv7_r <= DVW'(r[1]) - DVW'(r[0]);
      end
      if (en[8]) begin
        v8_r <= (VW'(dv7_r) <<< 1) + VW'(dv7_r);
      end
      if (en[9]) begin
        v9_r <= v8_r;
      end
    end

    bez_round_sat #(.IW(PW), .K(3 * F), .OW(CW)) u_fin_pos (
      .clk (clk),
      .en  (en[10]),
      .raw (pos_raw),
      .res (pos_o[ax])
    );

    bez_round_sat #(.IW(VW), .K(2 * F), .OW(CW)) u_fin_vel (
      .clk (clk),
      .en  (en[10]),
      .raw (v9_r),
      .res (vel_o[ax])
    );

    bez_round_sat #(.IW(AW), .K(F), .OW(CW)) u_fin_acc (
      .clk (clk),
      .en  (en[10]),
      .raw (acc_d_r[9]),
      .res (acc_o[ax])
    );
  end

  assign out_pos_x = pos_o[0];
  assign out_pos_y = pos_o[1];
  assign out_vel_x = vel_o[0];
  assign out_vel_y = vel_o[1];
  assign out_acc_x = acc_o[0];
  assign out_acc_y = acc_o[1];

  // With every stage full and the output held, no new item may enter.
  `BEZ_ASSERT_SAME(a_full_blocks_input, (&v_r) && !out_ready, !in_ready,
    "input taken while the pipeline is full and stalled")

  // An accepted item must occupy the input stage in the next cycle.
  `BEZ_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_r[0],
    "accepted item did not enter the input stage")

  // The parameter seen by the first row never exceeds one.
  `BEZ_ASSERT_SAME(a_t_clamped, v_r[0], t_r[0] <= T_ONE,
    "curve parameter above one reached the cells")

  // A delivered result with nothing behind it leaves the output empty.
  `BEZ_ASSERT_NEXT(a_output_drains, out_valid && out_ready && !v_r[NSTG-2], !out_valid,
    "result repeated after delivery")

endmodule

[dv/cubic_bezier_evaluator_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator testbench
// Drives curve parameters through the evaluator under a series of control
// point settings. A scoreboard predicts the point, first derivative and second
// derivative of every accepted item with exact wide arithmetic. It then checks
// each result item against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cubic_bezier_evaluator_top_test;
  import bez_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int F  = T_FRAC_BITS_DEF;

  localparam int PIPE_LATENCY = 11;

  localparam logic [F:0] T_ONE = (F + 1)'(1) << F;
  localparam logic [F:0] T_MAX = '1;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // Exact results are formed at 128 bits, which holds P * 2^(3F) with room left.
  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (CW - 1)) - 128'sd1;
  localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (CW - 1));

  typedef struct {
    logic [F:0]           param_t;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic signed [CW-1:0] acc_x;
    logic signed [CW-1:0] acc_y;
  } curve_sample_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the control points, predicts one curve
  // sample per accepted item and checks result items in order.
  // --------------------------------------------------------------------------
  class curve_scoreboard;
    logic signed [CW-1:0] ctrl_pts [NUM_REGS];
    curve_sample_t        pending_samples [$];
    int                   errors;

    function new();
      foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
      errors = 0;
    endfunction

    function void set_point(cfg_reg_t idx, logic signed [CW-1:0] value);
      ctrl_pts[idx] = value;
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    // Round to nearest with ties upward after dropping k bits, then clip.
    function logic signed [CW-1:0] round_sat(logic signed [127:0] n, int k);
      logic signed [127:0] r;
      r = (n + (128'sd1 <<< (k - 1))) >>> k;
      if (r > SAT_HI) return COORD_MAX;
      if (r < SAT_LO) return COORD_MIN;
      return r[CW-1:0];
    endfunction

    // Bernstein form of one axis: point, first and second derivative.
    function void eval_axis(input logic signed [CW-1:0] c0, c1, c2, c3,
                            input logic signed [127:0] t, s,
                            output logic signed [CW-1:0] pos, vel, acc);
      logic signed [127:0] a0, a1, a2, a3, d0, d1, d2, e0, e1, n;
      a0 = 128'(c0);
      a1 = 128'(c1);
      a2 = 128'(c2);
      a3 = 128'(c3);
      n = a0 * s * s * s + 3 * a1 * t * s * s + 3 * a2 * t * t * s + a3 * t * t * t;
      pos = round_sat(n, 3 * F);
      d0 = a1 - a0;
      d1 = a2 - a1;
      d2 = a3 - a2;
      n = 3 * (d0 * s * s + 2 * d1 * t * s + d2 * t * t);
      vel = round_sat(n, 2 * F);
      e0 = d1 - d0;
      e1 = d2 - d1;
      n = 6 * (e0 * s + e1 * t);
      acc = round_sat(n, F);
    endfunction

    function void note_param(logic [F:0] raw_t);
      logic signed [127:0] t, s;
      curve_sample_t       exp_s;
      // Anything above 1.0 is evaluated as 1.0.
      t = 128'((raw_t > T_ONE) ? T_ONE : raw_t);
      s = (128'sd1 <<< F) - t;
      exp_s.param_t = raw_t;
      eval_axis(ctrl_pts[REG_START_X], ctrl_pts[REG_LEAD_X], ctrl_pts[REG_TRAIL_X],
                ctrl_pts[REG_END_X], t, s, exp_s.pos_x, exp_s.vel_x, exp_s.acc_x);
      eval_axis(ctrl_pts[REG_START_Y], ctrl_pts[REG_LEAD_Y], ctrl_pts[REG_TRAIL_Y],
                ctrl_pts[REG_END_Y], t, s, exp_s.pos_y, exp_s.vel_y, exp_s.acc_y);
      pending_samples.push_back(exp_s);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [F:0] param_t,
                     logic signed [CW-1:0] got, logic signed [CW-1:0] exp_v);
      if (got !== exp_v)
        report($sformatf("t=0x%05h %s got %0d (0x%08h) expected %0d (0x%08h)",
                         param_t, name, got, got, exp_v, exp_v));
    endtask

    task check_sample(curve_sample_t got);
      curve_sample_t exp_s;
      if (pending_samples.size() == 0) begin
        report("result item with no accepted item waiting for it");
      end else begin
        exp_s = pending_samples.pop_front();
        check_field("pos_x", exp_s.param_t, got.pos_x, exp_s.pos_x);
        check_field("pos_y", exp_s.param_t, got.pos_y, exp_s.pos_y);
        check_field("vel_x", exp_s.param_t, got.vel_x, exp_s.vel_x);
        check_field("vel_y", exp_s.param_t, got.vel_y, exp_s.vel_y);
        check_field("acc_x", exp_s.param_t, got.acc_x, exp_s.acc_x);
        check_field("acc_y", exp_s.param_t, got.acc_y, exp_s.acc_y);
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test.
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]        cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [F:0]           in_param_t;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CW-1:0] out_pos_x;
  logic signed [CW-1:0] out_pos_y;
  logic signed [CW-1:0] out_vel_x;
  logic signed [CW-1:0] out_vel_y;
  logic signed [CW-1:0] out_acc_x;
  logic signed [CW-1:0] out_acc_y;

  cubic_bezier_evaluator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_param_t (in_param_t),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_vel_x  (out_vel_x),
    .out_vel_y  (out_vel_y),
    .out_acc_x  (out_acc_x),
    .out_acc_y  (out_acc_y)
  );

  curve_scoreboard sb;

  // When set, the receiver stops stalling; the last phase runs at full rate.
  bit quiet;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Receiver: unless quiet is set, out_ready alternates random runs of readiness
  // with random stall bursts. Now and then a long ready run gives a stretch with
  // no stalls at all. With quiet set, out_ready stays high.
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // Every result item accepted at this edge goes to the scoreboard. Values are
  // read as they stood before the edge, since all drivers use nonblocking
  // assignments.
  always @(posedge clk) begin
    curve_sample_t got;
    if (rst_n && out_valid && out_ready) begin
      got.param_t = '0;
      got.pos_x   = out_pos_x;
      got.pos_y   = out_pos_y;
      got.vel_x   = out_vel_x;
      got.vel_y   = out_vel_y;
      got.acc_x   = out_acc_x;
      got.acc_y   = out_acc_y;
      sb.check_sample(got);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Each one starts and ends on a rising edge.
  // --------------------------------------------------------------------------

  // Writes all eight control point registers on back-to-back cycles and keeps
  // the scoreboard's copy in step. Only called while nothing is in flight.
  task load_curve(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                  logic signed [CW-1:0] lx, logic signed [CW-1:0] ly,
                  logic signed [CW-1:0] tx, logic signed [CW-1:0] ty,
                  logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
    logic signed [CW-1:0] pts [NUM_REGS];
    pts[REG_START_X] = sx;
    pts[REG_START_Y] = sy;
    pts[REG_LEAD_X]  = lx;
    pts[REG_LEAD_Y]  = ly;
    pts[REG_TRAIL_X] = tx;
    pts[REG_TRAIL_Y] = ty;
    pts[REG_END_X]   = ex;
    pts[REG_END_Y]   = ey;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= pts[i];
      sb.set_point(cfg_reg_t'(i), pts[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one item after an optional idle gap and waits until it is taken.
  task send_param(logic [F:0] t, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_param_t <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_param(t);
  endtask

  // Drops valid and waits until every predicted item has come back.
  task drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Drains, then lets the pipeline settle before control points change.
  task settle();
    drain_pipe();
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    logic signed [CW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1: return v;
      // Moderate magnitudes keep most results away from the clip bounds.
      2, 3: return v >>> $urandom_range(6, 28);
      4: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default: return $urandom_range(0, 1) ? '0 : (v >>> 29);
    endcase
  endfunction

  function automatic logic [F:0] pick_param();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return (F + 1)'(1);
          2: return (F + 1)'(T_ONE - 1);
          3: return T_ONE >> 1;
          default: return T_ONE;
        endcase
      end
      // Values above 1.0 must behave exactly like 1.0.
      1: return (F + 1)'($urandom_range(T_ONE + 1, T_MAX));
      default: return (F + 1)'($urandom_range(0, T_ONE));
    endcase
  endfunction

  // One random phase: a fresh curve, then a run of items. The sender idles on
  // idle_pct percent of the items. At pause_at it holds off until the pipeline
  // is empty, which shows the block restarts cleanly from an empty state.
  task run_phase(int n_items, int idle_pct, int pause_at);
    int gap;
    settle();
    load_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord(), pick_coord());
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) drain_pipe();
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 19) : 0;
      send_param(pick_param(), gap);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [F:0] sweep [$];
    sb         = new();
    quiet      = 1'b0;
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_START_X;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_param_t = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset leaves every control point at zero, so everything must read zero,
    // including the largest input code, which is clamped to 1.0.
    send_param('0, 0);
    send_param(T_ONE, 0);
    send_param(T_MAX, 0);

    // Control points at alternating extremes drive the derivatives far past
    // the output range on both sides. The sweep covers both ends of t, the
    // codes next to them, the midpoint and codes above 1.0.
    settle();
    load_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
               COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    sweep = '{'0, (F + 1)'(1), T_ONE >> 1, (F + 1)'(T_ONE - 1), T_ONE,
              (F + 1)'(T_ONE + 1), T_MAX, 17'h0AAAA};
    foreach (sweep[i]) send_param(sweep[i], 0);

    // A flat curve at either bound: the point sits on the bound and both
    // derivatives are zero for every t.
    settle();
    load_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
               COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    sweep = '{'0, 17'd40000, T_ONE};
    foreach (sweep[i]) send_param(sweep[i], 0);
    settle();
    load_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
               COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    sweep = '{'0, 17'd20000, T_ONE};
    foreach (sweep[i]) send_param(sweep[i], 0);

    // At t = 0.5 a start point of +4 or -4 LSB lands the point exactly halfway
    // between two codes, so the tie rounding is seen on both signs.
    settle();
    load_curve(4, -4, 0, 0, 0, 0, 0, 0);
    sweep = '{T_ONE >> 1, T_ONE >> 2, 17'hC000};
    foreach (sweep[i]) send_param(sweep[i], 0);

    // Random phases with fresh curves. One phase pauses in the middle until
    // the pipeline is empty. The last one runs with no idling on either side.
    for (int p = 0; p < 8; p++) begin
      if (p == 7) quiet = 1'b1;
      run_phase(200, (p == 7) ? 0 : $urandom_range(0, 2) * 20, (p == 2) ? 100 : -1);
    end

    drain_pipe();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected result items never arrived");
    if (sb.errors == 0) begin
      $display("cubic_bezier_evaluator_top_test passed");
    end else begin
      $display("cubic_bezier_evaluator_top_test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this sequence.
  initial begin
    #5000000;
    $display("cubic_bezier_evaluator_top_test failed");
    $finish;
  end

endmodule
